// ===== rtl/kpad_pkg.sv =====
package kpad_pkg;

  localparam int SCAN_W = 16;
  localparam int KEY_IDX_W = 4;
  localparam int CODE_W = 7;
  localparam int DUTY_W = 8;

  localparam logic [DUTY_W-1:0] DUTY_RESET = 8'd50;
  localparam logic [DUTY_W-1:0] STEP_RESET = 8'd25;

  // characters that steer the duty levels
  localparam logic [CODE_W-1:0] CHAR_ONE   = 7'h31;
  localparam logic [CODE_W-1:0] CHAR_TWO   = 7'h32;
  localparam logic [CODE_W-1:0] CHAR_FOUR  = 7'h34;
  localparam logic [CODE_W-1:0] CHAR_FIVE  = 7'h35;
  localparam logic [CODE_W-1:0] CHAR_SEVEN = 7'h37;
  localparam logic [CODE_W-1:0] CHAR_EIGHT = 7'h38;
  localparam logic [CODE_W-1:0] CHAR_NONE  = 7'h00;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_A_UP,
    ACT_A_DOWN,
    ACT_B_UP,
    ACT_B_DOWN,
    ACT_C_UP,
    ACT_C_DOWN
  } act_t;

  typedef struct packed {
    logic              seen;
    logic [CODE_W-1:0] code;
    act_t              act;
  } key_info_t;

  typedef struct packed {
    logic [DUTY_W-1:0] a;
    logic [DUTY_W-1:0] b;
    logic [DUTY_W-1:0] c;
  } duty_set_t;

  // key table, bit 0 upward: * 0 # D 7 8 9 C 4 5 6 B 1 2 3 A
  function automatic logic [CODE_W-1:0] key_char(input logic [KEY_IDX_W-1:0] idx);
    logic [CODE_W-1:0] ch;
    unique case (idx)
      4'd0:  ch = 7'h2A;
      4'd1:  ch = 7'h30;
      4'd2:  ch = 7'h23;
      4'd3:  ch = 7'h44;
      4'd4:  ch = 7'h37;
      4'd5:  ch = 7'h38;
      4'd6:  ch = 7'h39;
      4'd7:  ch = 7'h43;
      4'd8:  ch = 7'h34;
      4'd9:  ch = 7'h35;
      4'd10: ch = 7'h36;
      4'd11: ch = 7'h42;
      4'd12: ch = 7'h31;
      4'd13: ch = 7'h32;
      4'd14: ch = 7'h33;
      default: ch = 7'h41;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/kpad_encode.sv =====
module kpad_encode (
  input  logic [kpad_pkg::SCAN_W-1:0] scan_first,
  input  logic [kpad_pkg::SCAN_W-1:0] scan_second,
  input  logic [kpad_pkg::SCAN_W-1:0] previous_pressed,
  output logic [kpad_pkg::SCAN_W-1:0] pressed,
  output kpad_pkg::key_info_t         info
);
  import kpad_pkg::*;

  logic [SCAN_W-1:0]    fresh;
  logic [KEY_IDX_W-1:0] idx;
  logic [CODE_W-1:0]    ch;

  assign pressed = scan_first & scan_second;
  assign fresh   = pressed & ~previous_pressed;

  // lowest set bit wins, so scan from the top down
  always_comb begin
    idx = '0;
    for (int i = SCAN_W - 1; i >= 0; i--) begin
      if (fresh[i]) begin
        idx = KEY_IDX_W'(i);
      end
    end
  end

  assign ch = key_char(idx);

  always_comb begin
    info.seen = |fresh;
    info.code = info.seen ? ch : CHAR_NONE;
    info.act  = ACT_NONE;
    if (info.seen) begin
      unique case (ch)
        CHAR_ONE:   info.act = ACT_A_UP;
        CHAR_TWO:   info.act = ACT_A_DOWN;
        CHAR_FOUR:  info.act = ACT_B_UP;
        CHAR_FIVE:  info.act = ACT_B_DOWN;
        CHAR_SEVEN: info.act = ACT_C_UP;
        CHAR_EIGHT: info.act = ACT_C_DOWN;
        default:    info.act = ACT_NONE;
      endcase
    end
  end

endmodule

// ===== rtl/kpad_levels.sv =====
module kpad_levels (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [kpad_pkg::DUTY_W-1:0]  cfg_wr_data,
  input  logic                         advance,
  input  logic [kpad_pkg::SCAN_W-1:0]  pressed,
  input  kpad_pkg::key_info_t          info,
  output logic [kpad_pkg::SCAN_W-1:0]  previous_pressed,
  output kpad_pkg::duty_set_t          duty_next
);
  import kpad_pkg::*;

  logic [DUTY_W-1:0] step_size;
  duty_set_t         duty;

  always_comb begin
    duty_next = duty;
    unique case (info.act)
      ACT_A_UP:   duty_next.a = duty.a + step_size;
      ACT_A_DOWN: duty_next.a = duty.a - step_size;
      ACT_B_UP:   duty_next.b = duty.b + step_size;
      ACT_B_DOWN: duty_next.b = duty.b - step_size;
      ACT_C_UP:   duty_next.c = duty.c + step_size;
      ACT_C_DOWN: duty_next.c = duty.c - step_size;
      default:    duty_next = duty;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size        <= STEP_RESET;
      previous_pressed <= '0;
      duty             <= '{a: DUTY_RESET, b: DUTY_RESET, c: DUTY_RESET};
    end else begin
      if (cfg_wr_en) begin
        step_size <= cfg_wr_data;
      end
      if (advance) begin
        previous_pressed <= pressed;
        duty             <= duty_next;
      end
    end
  end

endmodule

// ===== rtl/keypad_edge_encode_duty_adjust.sv =====
// channel   dir  payload (lowest bit first)
// s_*       in   tdata: scan_first[15:0], scan_second[31:16]
// m_*       out  tdata: key_code[6:0], duty_a[14:7], duty_b[22:15], duty_c[30:23], zero
//                tuser: key_seen
// cfg_wr_*  in   step_size, written at any edge with cfg_wr_en high and rst low
//
// one request per cycle sustained while m_tready stays high; a taken request
// passes through the input register, then the result register, with the single
// pass through the encoder and the duty adder between them
// rst is synchronous: clears the key map, duty levels to 50, step to 25
// a stall on m_tready holds the result; the input register still takes one
// more request if it is empty before s_tready drops
module keypad_edge_encode_duty_adjust (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,     // scan_first, scan_second
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,     // key_code, duty_a, duty_b, duty_c, zero fill
  output logic [0:0]  m_tuser,     // key_seen
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data
);
  import kpad_pkg::*;

  logic              in_valid;
  logic [SCAN_W-1:0] in_first;
  logic [SCAN_W-1:0] in_second;
  logic              out_free;
  logic              advance;

  logic [SCAN_W-1:0] pressed;
  logic [SCAN_W-1:0] previous_pressed;
  key_info_t         info;
  duty_set_t         duty_next;

  logic              res_seen;
  logic [CODE_W-1:0] res_code;
  duty_set_t         res_duty;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  kpad_encode u_encode (
    .scan_first       (in_first),
    .scan_second      (in_second),
    .previous_pressed (previous_pressed),
    .pressed          (pressed),
    .info             (info)
  );

  kpad_levels u_levels (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .advance          (advance),
    .pressed          (pressed),
    .info             (info),
    .previous_pressed (previous_pressed),
    .duty_next        (duty_next)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_first  <= s_tdata[SCAN_W-1:0];
      in_second <= s_tdata[2*SCAN_W-1:SCAN_W];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
    if (advance) begin
      res_seen <= info.seen;
      res_code <= info.code;
      res_duty <= duty_next;
    end
  end

  assign m_tdata = {1'b0, res_duty.c, res_duty.b, res_duty.a, res_code};
  assign m_tuser = res_seen;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import kpad_pkg::*;

  localparam int PIPE_LAT = 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_SCANS = 240;
  // key characters, bit 0 in the lowest byte
  localparam logic [16*8-1:0] KEY_ROW = "A321B654C987D#0*";

  typedef struct packed {
    logic              seen;
    logic [CODE_W-1:0] code;
    logic [DUTY_W-1:0] a;
    logic [DUTY_W-1:0] b;
    logic [DUTY_W-1:0] c;
  } key_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  // predictor state
  logic [SCAN_W-1:0] held_map;
  logic [DUTY_W-1:0] lvl_a, lvl_b, lvl_c;
  logic [DUTY_W-1:0] step_now;

  logic [31:0]  pending_scans[$];
  key_report_t  expected_reports[$];
  int unsigned  errors = 0;
  int unsigned  stall_odds = 0;
  int unsigned  src_gap = 0;
  int unsigned  sink_gap = 0;
  int unsigned  idle_cycles = 0;

  keypad_edge_encode_duty_adjust dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic key_report_t predict_key_report(input logic [SCAN_W-1:0] first,
                                                     input logic [SCAN_W-1:0] second);
    logic [SCAN_W-1:0] now_map;
    logic [SCAN_W-1:0] fresh;
    key_report_t       rep;
    act_t              act;
    now_map = first & second;
    fresh = now_map & ~held_map;
    held_map = now_map;
    rep.seen = |fresh;
    rep.code = CHAR_NONE;
    act = ACT_NONE;
    // scan downwards so the lowest new key wins
    for (int i = SCAN_W - 1; i >= 0; i--)
      if (fresh[i]) rep.code = KEY_ROW[i*8 +: CODE_W];
    case (rep.code)
      CHAR_ONE:   act = ACT_A_UP;
      CHAR_TWO:   act = ACT_A_DOWN;
      CHAR_FOUR:  act = ACT_B_UP;
      CHAR_FIVE:  act = ACT_B_DOWN;
      CHAR_SEVEN: act = ACT_C_UP;
      CHAR_EIGHT: act = ACT_C_DOWN;
      default:    act = ACT_NONE;
    endcase
    case (act)
      ACT_A_UP:   lvl_a = lvl_a + step_now;
      ACT_A_DOWN: lvl_a = lvl_a - step_now;
      ACT_B_UP:   lvl_b = lvl_b + step_now;
      ACT_B_DOWN: lvl_b = lvl_b - step_now;
      ACT_C_UP:   lvl_c = lvl_c + step_now;
      ACT_C_DOWN: lvl_c = lvl_c - step_now;
      default: ;
    endcase
    rep.a = lvl_a;
    rep.b = lvl_b;
    rep.c = lvl_c;
    return rep;
  endfunction

  function automatic logic [31:0] random_scan();
    logic [SCAN_W-1:0] first;
    logic [SCAN_W-1:0] second;
    int unsigned       kind;
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      // clean single press, at least half of them on the duty keys
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 5))
          0: first = 16'h1000;
          1: first = 16'h2000;
          2: first = 16'h0100;
          3: first = 16'h0200;
          4: first = 16'h0010;
          default: first = 16'h0020;
        endcase
      end else begin
        first = 16'h0001 << $urandom_range(0, 15);
      end
      second = first;
    end else if (kind < 65) begin
      first = '0;
      second = '0;
    end else if (kind < 80) begin
      // bounce on one key
      first = SCAN_W'($urandom);
      second = first ^ (16'h0001 << $urandom_range(0, 15));
    end else if (kind < 90) begin
      first = SCAN_W'($urandom);
      second = first;
    end else begin
      first = SCAN_W'($urandom);
      second = SCAN_W'($urandom);
    end
    return {second, first};
  endfunction

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // wait for the pipe to empty, then give it its latency
  task automatic drain();
    while (pending_scans.size() != 0 || s_tvalid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic write_step(input logic [7:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    step_now = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic push_scan(input logic [SCAN_W-1:0] first, input logic [SCAN_W-1:0] second);
    pending_scans.push_back({second, first});
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_tvalid && s_tready)
        expected_reports.push_back(predict_key_report(s_tdata[15:0], s_tdata[31:16]));
      if (!(s_tvalid && !s_tready)) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_scans.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
          src_gap = $urandom_range(0, 6);
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_scans.pop_front();
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    key_report_t want;
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_reports.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none, actual code %0d", $time,
                   m_tdata[6:0]);
        end else begin
          want = expected_reports.pop_front();
          check_field("key_seen", want.seen, m_tuser[0]);
          check_field("key_code", want.code, m_tdata[6:0]);
          check_field("duty_a", want.a, m_tdata[14:7]);
          check_field("duty_b", want.b, m_tdata[22:15]);
          check_field("duty_c", want.c, m_tdata[30:23]);
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        sink_gap = $urandom_range(0, 6);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    held_map = '0;
    lvl_a = DUTY_RESET;
    lvl_b = DUTY_RESET;
    lvl_c = DUTY_RESET;
    step_now = STEP_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed requests at the reset step
    stall_odds = 6;
    push_scan(16'h0000, 16'h0000);
    push_scan(16'hFFFF, 16'hFFFF);
    push_scan(16'hFFFF, 16'hFFFF);
    push_scan(16'hFFFF, 16'h0000);
    push_scan(16'h1000, 16'h1000);
    push_scan(16'h2000, 16'h2000);
    push_scan(16'h0100, 16'h0100);
    push_scan(16'h0200, 16'h0200);
    push_scan(16'h0010, 16'h0010);
    push_scan(16'h0020, 16'h0020);
    push_scan(16'h8000, 16'h8000);
    push_scan(16'h0000, 16'hFFFF);
    push_scan(16'h3000, 16'h3000);
    push_scan(16'h3300, 16'h3300);
    push_scan(16'hAAAA, 16'h5555);
    push_scan(16'h5555, 16'hAAAA);
    push_scan(16'h0002, 16'h0002);
    // repeated lowering of duty a wraps below zero
    for (int i = 0; i < 4; i++) begin
      push_scan(16'h2000, 16'h2000);
      if (i < 3) push_scan(16'h0000, 16'h0000);
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      case (ph)
        0: write_step(8'd255);
        1: write_step(8'd0);
        2: write_step(8'd1);
        3: write_step(8'd128);
        4: write_step(8'($urandom_range(2, 254)));
        default: write_step(8'($urandom_range(0, 255)));
      endcase
      case (ph)
        0: stall_odds = 4;
        1: stall_odds = 16;
        3: stall_odds = 3;
        4: stall_odds = 8;
        default: stall_odds = 0;
      endcase
      repeat (PHASE_SCANS) pending_scans.push_back(random_scan());
    end

    drain();
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (errors == 0 && expected_reports.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
